// File: design/rgbci_pkg.sv
// Shared types, constants and the cosine weight builder for the RGB color interpolator.
`timescale 1ns / 1ps

package rgbci_pkg;

    // Channel and blend format
    localparam int FRACTION_BITS = 16;
    localparam int CH_W          = 17;
    localparam int MODE_W        = 3;
    localparam int NUM_CH        = 3;
    localparam int COSINE_TABLE_ENTRIES = 256;
    localparam int ACC_W         = 2 * CH_W;

    localparam logic [CH_W-1:0] ONE = CH_W'(1 << FRACTION_BITS);

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COSINE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SMOOTH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BEZIER = 3'd4;

    // Multiply-accumulate term indexes
    localparam logic [1:0] TERM_START   = 2'd0;
    localparam logic [1:0] TERM_CONTROL = 2'd1;
    localparam logic [1:0] TERM_END     = 2'd2;
    localparam logic [1:0] TERMS_MOVE   = 2'd1;
    localparam logic [1:0] TERMS_BEZIER = 2'd3;

    // pi/2 in Q30 and the rounding shift for sin^2
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          SQ_SHIFT    = 60 - FRACTION_BITS;

    // What one item does to the color
    typedef enum logic [1:0] {
        KIND_HOLD,
        KIND_LOAD,
        KIND_MOVE,
        KIND_BEZIER
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGHT_A,
        ST_WEIGHT_B,
        ST_MAC,
        ST_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       weight_a;
        logic       weight_b;
        logic       mac_issue;
        logic       mac_acc;
        logic       mac_first;
        logic [1:0] mac_term;
        logic       commit;
        kind_t      kind;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
    } stat_t;

    // sin^2 of a Q30 angle as a Q16 weight; elaboration only
    function automatic logic [CH_W-1:0] cos_weight_of_angle(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        s;
        logic [63:0]        w;
        logic signed [63:0] sum;
        int unsigned        n;
        a2   = (a * a) >> 30;
        term = a;
        sum  = signed'(a);
        for (n = 1; n <= 10; n++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            s = 64'd0;
        else
            s = unsigned'(sum);
        if (s > (64'd1 << 30))
            s = 64'd1 << 30;
        w = (s * s + (64'd1 << (SQ_SHIFT - 1))) >> SQ_SHIFT;
        if (w > 64'(ONE))
            w = 64'(ONE);
        return w[CH_W-1:0];
    endfunction

endpackage

// File: design/rgbci_ctrl.sv
// Sequencing controller for the RGB color interpolator.
`timescale 1ns / 1ps

module rgbci_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rgbci_pkg::stat_t  stat,
    output rgbci_pkg::cmd_t   cmd
);

    rgbci_pkg::state_t state_reg, state_next;
    rgbci_pkg::kind_t  kind_reg, kind_next;
    logic [1:0]        term_reg, term_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        terms;
    logic              slot_free;

    assign terms     = (kind_reg == rgbci_pkg::KIND_BEZIER) ? rgbci_pkg::TERMS_BEZIER
                                                            : rgbci_pkg::TERMS_MOVE;
    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        term_next  = term_reg;
        case (state_reg)
            rgbci_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = stat.kind;
                    if (stat.kind == rgbci_pkg::KIND_HOLD || stat.kind == rgbci_pkg::KIND_LOAD)
                        state_next = rgbci_pkg::ST_COMMIT;
                    else
                        state_next = rgbci_pkg::ST_WEIGHT_A;
                end
            end
            rgbci_pkg::ST_WEIGHT_A:
            begin
                state_next = rgbci_pkg::ST_WEIGHT_B;
            end
            rgbci_pkg::ST_WEIGHT_B:
            begin
                state_next = rgbci_pkg::ST_MAC;
                term_next  = rgbci_pkg::TERM_START;
            end
            rgbci_pkg::ST_MAC:
            begin
                term_next = term_reg + 2'd1;
                if (term_reg == terms)
                    state_next = rgbci_pkg::ST_COMMIT;
            end
            rgbci_pkg::ST_COMMIT:
            begin
                if (slot_free)
                    state_next = rgbci_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rgbci_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd           = '0;
        cmd.kind      = kind_reg;
        cmd.mac_term  = term_reg;
        in_ready      = 1'b0;
        case (state_reg)
            rgbci_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            rgbci_pkg::ST_WEIGHT_A:
            begin
                cmd.weight_a = 1'b1;
            end
            rgbci_pkg::ST_WEIGHT_B:
            begin
                cmd.weight_b = 1'b1;
            end
            rgbci_pkg::ST_MAC:
            begin
                cmd.mac_issue = (term_reg < terms);
                cmd.mac_acc   = (term_reg != rgbci_pkg::TERM_START);
                cmd.mac_first = (term_reg == rgbci_pkg::TERM_CONTROL);
            end
            rgbci_pkg::ST_COMMIT:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output slot: set on commit, cleared when the item is taken
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgbci_pkg::ST_IDLE;
            kind_reg      <= rgbci_pkg::KIND_HOLD;
            term_reg      <= rgbci_pkg::TERM_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed color not presented");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgbci_pkg::ST_MAC) |-> (term_reg <= terms))
        else $error("mac term past last");

    a_first_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac_acc && cmd.mac_first) |-> $past(cmd.mac_issue))
        else $error("accumulate without product");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgbci_pkg::ST_COMMIT && out_valid_reg && !out_ready)
            |=> (state_reg == rgbci_pkg::ST_COMMIT))
        else $error("commit left while output stalled");

endmodule

// File: design/rgbci_datapath.sv
// Datapath for the RGB color interpolator: weight stages, per-channel MAC lanes, color store.
`timescale 1ns / 1ps

module rgbci_datapath
#(
    parameter int COSINE_TABLE_ENTRIES = rgbci_pkg::COSINE_TABLE_ENTRIES
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [rgbci_pkg::MODE_W-1:0]                  in_mode,
    input  logic [rgbci_pkg::CH_W-1:0]                    in_blend,
    input  logic [rgbci_pkg::NUM_CH-1:0][rgbci_pkg::CH_W-1:0] in_target,
    input  logic [rgbci_pkg::NUM_CH-1:0][rgbci_pkg::CH_W-1:0] in_control,
    input  rgbci_pkg::cmd_t                               cmd,
    output rgbci_pkg::stat_t                              stat,
    output logic [rgbci_pkg::NUM_CH-1:0][rgbci_pkg::CH_W-1:0] out_color
);

    localparam int CH_W   = rgbci_pkg::CH_W;
    localparam int FB     = rgbci_pkg::FRACTION_BITS;
    localparam int NCH    = rgbci_pkg::NUM_CH;
    localparam int ACC_W  = rgbci_pkg::ACC_W;
    localparam int N      = COSINE_TABLE_ENTRIES;
    localparam int IDX_W  = $clog2(N + 1);
    localparam int P_W    = CH_W + IDX_W;
    localparam logic [IDX_W-1:0] N_VAL     = IDX_W'(N);
    localparam logic [CH_W:0]    THREE_ONE = (CH_W + 1)'(3 << FB);

    // Cosine weight table, built at elaboration
    logic [CH_W-1:0] cos_tab [N+1];

    for (genvar k = 0; k <= N; k++)
    begin : g_tab
        localparam logic [63:0] Angle = (rgbci_pkg::HALF_PI_Q30 * k) / N;
        if (k == 0)
        begin : g_zero
            assign cos_tab[k] = '0;
        end
        else if (k == N)
        begin : g_full
            assign cos_tab[k] = rgbci_pkg::ONE;
        end
        else
        begin : g_mid
            assign cos_tab[k] = rgbci_pkg::cos_weight_of_angle(Angle);
        end
    end

    // Captured item
    logic [rgbci_pkg::MODE_W-1:0]    mode_reg;
    logic [CH_W-1:0]                 t_reg;
    logic [NCH-1:0][CH_W-1:0]        tgt_reg;
    logic [NCH-1:0][CH_W-1:0]        ctl_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [FB-1:0]                   frac_reg;

    // Weight stage A
    logic [CH_W-1:0]                 sq_reg, ws_reg, wc_reg;
    logic [CH_W-1:0]                 lo_reg, hi_reg;
    logic [NCH-1:0][CH_W-1:0]        mag_reg;
    logic [NCH-1:0]                  up_reg;

    // Weight stage B and MAC lanes
    logic [CH_W-1:0]                 w_reg;
    logic [NCH-1:0][ACC_W-1:0]       prod_reg;
    logic [NCH-1:0][ACC_W-1:0]       acc_reg;

    // Current color
    logic [NCH-1:0][CH_W-1:0]        cur_reg, cur_next;

    logic [P_W-1:0]                  p_full;
    logic [IDX_W-1:0]                idx_hi;
    logic [CH_W-1:0]                 u_val;
    logic [ACC_W-1:0]                tt_prod, uu_prod, ut_prod;
    logic [CH_W-1:0]                 hi_c, span, cos_w, w_val;
    logic [CH_W+FB-1:0]              cos_prod;
    logic [CH_W:0]                   smooth_fac;
    logic [ACC_W:0]                  smooth_prod;
    logic [NCH-1:0][CH_W-1:0]        op_a;
    logic [CH_W-1:0]                 op_b;

    // Item classification from the live input
    always_comb
    begin
        if (in_mode == rgbci_pkg::MODE_LOAD)
            stat.kind = rgbci_pkg::KIND_LOAD;
        else if (in_mode > rgbci_pkg::MODE_BEZIER || in_blend == '0)
            stat.kind = rgbci_pkg::KIND_HOLD;
        else if (in_blend >= rgbci_pkg::ONE)
            stat.kind = rgbci_pkg::KIND_LOAD;
        else if (in_mode == rgbci_pkg::MODE_BEZIER)
            stat.kind = rgbci_pkg::KIND_BEZIER;
        else
            stat.kind = rgbci_pkg::KIND_MOVE;
    end

    // Table position t*N, split at capture
    assign p_full = P_W'(in_blend) * P_W'(N_VAL);

    // Stage A products
    assign idx_hi  = IDX_W'(idx_reg + 1'b1);
    assign u_val   = rgbci_pkg::ONE - t_reg;
    assign tt_prod = ACC_W'(t_reg) * ACC_W'(t_reg);
    assign uu_prod = ACC_W'(u_val) * ACC_W'(u_val);
    assign ut_prod = ACC_W'(u_val) * ACC_W'(t_reg);

    // Stage B weight select
    assign hi_c        = (hi_reg < lo_reg) ? lo_reg : hi_reg;
    assign span        = hi_c - lo_reg;
    assign cos_prod    = (CH_W + FB)'(span) * (CH_W + FB)'(frac_reg);
    assign cos_w       = lo_reg + cos_prod[FB +: CH_W];
    assign smooth_fac  = THREE_ONE - {t_reg, 1'b0};
    assign smooth_prod = (ACC_W + 1)'(sq_reg) * (ACC_W + 1)'(smooth_fac);

    always_comb
    begin
        case (mode_reg)
            rgbci_pkg::MODE_COSINE: w_val = cos_w;
            rgbci_pkg::MODE_SMOOTH: w_val = smooth_prod[FB +: CH_W];
            default:                w_val = t_reg;
        endcase
    end

    // MAC operand select per term
    always_comb
    begin
        case (cmd.mac_term)
            rgbci_pkg::TERM_START:
            begin
                if (cmd.kind == rgbci_pkg::KIND_BEZIER)
                begin
                    op_a = cur_reg;
                    op_b = ws_reg;
                end
                else
                begin
                    op_a = mag_reg;
                    op_b = w_reg;
                end
            end
            rgbci_pkg::TERM_END:
            begin
                op_a = tgt_reg;
                op_b = sq_reg;
            end
            default:
            begin
                op_a = ctl_reg;
                op_b = wc_reg;
            end
        endcase
    end

    // New color on commit
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            case (cmd.kind)
                rgbci_pkg::KIND_LOAD:
                    cur_next[c] = tgt_reg[c];
                rgbci_pkg::KIND_MOVE:
                    cur_next[c] = up_reg[c] ? cur_reg[c] + acc_reg[c][FB +: CH_W]
                                            : cur_reg[c] - acc_reg[c][FB +: CH_W];
                rgbci_pkg::KIND_BEZIER:
                    cur_next[c] = acc_reg[c][FB +: CH_W];
                default:
                    cur_next[c] = cur_reg[c];
            endcase
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            t_reg    <= in_blend;
            tgt_reg  <= in_target;
            ctl_reg  <= in_control;
            idx_reg  <= p_full[FB +: IDX_W];
            frac_reg <= p_full[FB-1:0];
        end
        if (cmd.weight_a)
        begin
            sq_reg <= tt_prod[FB +: CH_W];
            ws_reg <= uu_prod[FB +: CH_W];
            wc_reg <= ut_prod[FB-1 +: CH_W];
            lo_reg <= cos_tab[idx_reg];
            hi_reg <= cos_tab[idx_hi];
            for (int c = 0; c < NCH; c++)
            begin
                up_reg[c]  <= (tgt_reg[c] >= cur_reg[c]);
                mag_reg[c] <= (tgt_reg[c] >= cur_reg[c]) ? tgt_reg[c] - cur_reg[c]
                                                         : cur_reg[c] - tgt_reg[c];
            end
        end
        if (cmd.weight_b)
            w_reg <= w_val;
        for (int c = 0; c < NCH; c++)
        begin
            if (cmd.mac_issue)
                prod_reg[c] <= ACC_W'(op_a[c]) * ACC_W'(op_b);
            if (cmd.mac_acc)
                acc_reg[c] <= cmd.mac_first ? prod_reg[c] : acc_reg[c] + prod_reg[c];
        end
    end

    // Color store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (cmd.commit)
            cur_reg <= cur_next;
    end

    assign out_color = cur_reg;

endmodule

// File: design/rgb_color_interpolator.sv
// Top level of the RGB color interpolator: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Keeps one Q16 RGB color (reset to black) and applies one item at a time: load, or a move
// toward the target by t using a linear, cosine, smoothstep or quadratic Bezier blend; every
// item returns the color after it. A load, a hold (t of zero or an unused mode) or a snap
// (t of one or more) goes from acceptance straight to the commit state; a linear, cosine,
// smoothstep or Bezier move first passes two weight stages, then one multiply-accumulate
// lane per channel that takes the Bezier terms one per cycle. The next item is taken the
// cycle after the previous color is committed to the output register; a stalled output
// holds the commit.
module rgb_color_interpolator
#(
    parameter int COSINE_TABLE_ENTRIES = rgbci_pkg::COSINE_TABLE_ENTRIES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0], blend[19:3], target_red[36:20], target_green[53:37], target_blue[70:54],
    // control_red[87:71], control_green[104:88], control_blue[121:105], zero[127:122]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_red[16:0], out_green[33:17], out_blue[50:34], zero[55:51]
    output logic [55:0]  m_axis_tdata
);

    localparam int CH_W = rgbci_pkg::CH_W;
    localparam int NCH  = rgbci_pkg::NUM_CH;

    rgbci_pkg::cmd_t           cmd;
    rgbci_pkg::stat_t          stat;
    logic [NCH-1:0][CH_W-1:0]  target, control, color;

    // Unpack the input item
    assign target[0]  = s_axis_tdata[36:20];
    assign target[1]  = s_axis_tdata[53:37];
    assign target[2]  = s_axis_tdata[70:54];
    assign control[0] = s_axis_tdata[87:71];
    assign control[1] = s_axis_tdata[104:88];
    assign control[2] = s_axis_tdata[121:105];

    rgbci_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rgbci_datapath
    #(
        .COSINE_TABLE_ENTRIES (COSINE_TABLE_ENTRIES)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mode    (s_axis_tdata[2:0]),
        .in_blend   (s_axis_tdata[19:3]),
        .in_target  (target),
        .in_control (control),
        .cmd        (cmd),
        .stat       (stat),
        .out_color  (color)
    );

    // Pack the result item
    assign m_axis_tdata = {5'd0, color[2], color[1], color[0]};

endmodule

// File: test/rgb_color_interpolator_checker.sv
// Stream watcher for the RGB color interpolator: predicts each output color and compares it.
`timescale 1ns / 1ps

module rgb_color_interpolator_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // mode[2:0], blend[19:3], target rgb[70:20], control rgb[121:71], zero[127:122]
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_red[16:0], out_green[33:17], out_blue[50:34], zero[55:51]
    input  logic [55:0]  m_axis_tdata,
    output int           errors,
    output int           pending
);
    import rgbci_pkg::*;

    localparam int          TAB_N  = COSINE_TABLE_ENTRIES;
    localparam logic [63:0] UNIT   = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] ANG_ONE = 64'd1 << 30;

    // element 0 is red, in the lowest bits
    typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

    // sin^2 weights sampled over a quarter turn
    logic [63:0] sin_sq_tab [0:TAB_N];

    color_t color_now;
    color_t expected_colors [$];
    color_t got_color;
    color_t want_color;
    string  chan_name [NUM_CH] = '{"red", "green", "blue"};

    // one table entry: Taylor sine in Q30, squared and rounded to the channel format
    function automatic logic [63:0] sin_sq_entry(input int k);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] w;
        longint      acc;
        int          n;
        ang    = (HALF_PI_Q30 * 64'(k)) / 64'(TAB_N);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (n = 1; n <= 10; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        s = (acc < 0) ? 64'd0 : 64'(acc);
        if (s > ANG_ONE)
            s = ANG_ONE;
        w = (s * s + (64'd1 << (SQ_SHIFT - 1))) >> SQ_SHIFT;
        if (w > UNIT)
            w = UNIT;
        return w;
    endfunction

    initial
    begin
        for (int k = 0; k <= TAB_N; k++)
            sin_sq_tab[k] = sin_sq_entry(k);
        sin_sq_tab[0]     = 64'd0;
        sin_sq_tab[TAB_N] = UNIT;
    end

    // interpolated cosine ease weight for t below one
    function automatic logic [63:0] cosine_ease(input logic [63:0] t);
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        p    = t * 64'(TAB_N);
        idx  = p >> FRACTION_BITS;
        frac = p & (UNIT - 64'd1);
        if (idx >= 64'(TAB_N))
            return UNIT;
        lo = sin_sq_tab[idx];
        hi = sin_sq_tab[idx + 64'd1];
        if (hi < lo)
            hi = lo;
        return lo + (((hi - lo) * frac) >> FRACTION_BITS);
    endfunction

    // move one channel toward its target by weight w
    function automatic logic [CH_W-1:0] step_toward(input logic [63:0] c, input logic [63:0] g,
                                                   input logic [63:0] w);
        logic [63:0] r;
        if (g >= c)
            r = c + (((g - c) * w) >> FRACTION_BITS);
        else
            r = c - (((c - g) * w) >> FRACTION_BITS);
        return r[CH_W-1:0];
    endfunction

    // color after one item
    function automatic color_t next_color(input color_t cur, input logic [127:0] d);
        logic [MODE_W-1:0] mode;
        logic [63:0]       t;
        logic [63:0]       w;
        logic [63:0]       u;
        logic [63:0]       ws;
        logic [63:0]       wc;
        logic [63:0]       we;
        logic [63:0]       acc;
        color_t            tgt;
        color_t            ctl;
        color_t            nxt;
        mode = d[2:0];
        t    = 64'(d[19:3]);
        tgt  = d[70:20];
        ctl  = d[121:71];
        nxt  = cur;
        if (mode == MODE_LOAD)
            nxt = tgt;
        else if (mode <= MODE_BEZIER && t != 64'd0)
        begin
            if (t >= UNIT)
                nxt = tgt;
            else if (mode == MODE_BEZIER)
            begin
                u  = UNIT - t;
                ws = (u * u) >> FRACTION_BITS;
                wc = (64'd2 * u * t) >> FRACTION_BITS;
                we = (t * t) >> FRACTION_BITS;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    acc    = 64'(cur[c]) * ws + 64'(ctl[c]) * wc + 64'(tgt[c]) * we;
                    acc    = acc >> FRACTION_BITS;
                    nxt[c] = acc[CH_W-1:0];
                end
            end
            else
            begin
                if (mode == MODE_LINEAR)
                    w = t;
                else if (mode == MODE_COSINE)
                    w = cosine_ease(t);
                else
                    w = (((t * t) >> FRACTION_BITS) * (64'd3 * UNIT - 64'd2 * t))
                        >> FRACTION_BITS;
                for (int c = 0; c < NUM_CH; c++)
                    nxt[c] = step_toward(64'(cur[c]), 64'(tgt[c]), w);
            end
        end
        return nxt;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    initial
    begin
        errors    = 0;
        pending   = 0;
        color_now = '0;
    end

    // results are checked before the same edge's input is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_color = m_axis_tdata[NUM_CH*CH_W-1:0];
                if (expected_colors.size() == 0)
                    report($sformatf("result %h with no color expected", got_color));
                else
                begin
                    want_color = expected_colors.pop_front();
                    for (int c = 0; c < NUM_CH; c++)
                        if (got_color[c] !== want_color[c])
                            report($sformatf("%s got %0d expected %0d", chan_name[c],
                                             got_color[c], want_color[c]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                color_now = next_color(color_now, s_axis_tdata);
                expected_colors.push_back(color_now);
            end
        end
        pending <= expected_colors.size();
    end

endmodule

// File: test/rgb_color_interpolator_tb.sv
// Testbench top for the RGB color interpolator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rgb_color_interpolator_tb;
    import rgbci_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 184;
    localparam logic [CH_W-1:0] MAXV = {CH_W{1'b1}};

    typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

    typedef struct packed {
        color_t            control;
        color_t            target;
        logic [CH_W-1:0]   blend;
        logic [MODE_W-1:0] mode;
    } step_item_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;

    int          errors;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct = 51;
    logic        hold_go = 1'b0;
    logic        hold_rx = 1'b0;
    int unsigned cycle_count = 0;

    always #5 clk = ~clk;

    rgb_color_interpolator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rgb_color_interpolator_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    // receiver: random idling, forced off during the long hold
    always @(posedge clk)
        m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic color_t gray(input logic [CH_W-1:0] v);
        return {v, v, v};
    endfunction

    function automatic step_item_t mk(input logic [MODE_W-1:0] mode,
                                      input logic [CH_W-1:0] blend,
                                      input color_t tgt, input color_t ctl);
        step_item_t it;
        it.mode    = mode;
        it.blend   = blend;
        it.target  = tgt;
        it.control = ctl;
        return it;
    endfunction

    // mostly in range, some edges, some full 17-bit values
    function automatic logic [CH_W-1:0] rand_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return ONE;
        if (r == 2)
            return CH_W'($urandom);
        return CH_W'($urandom_range(0, 65536));
    endfunction

    function automatic color_t rand_color();
        color_t c;
        for (int k = 0; k < NUM_CH; k++)
            c[k] = rand_chan();
        return c;
    endfunction

    function automatic logic [CH_W-1:0] rand_blend();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return ONE;
        if (r == 2)
            return CH_W'($urandom);
        if (r == 3)
            return CH_W'($urandom_range(1, 15));
        if (r == 4)
            return ONE - CH_W'($urandom_range(1, 15));
        return CH_W'($urandom_range(1, 65535));
    endfunction

    function automatic step_item_t rand_item();
        step_item_t it;
        int         r;
        r = $urandom_range(0, 19);
        if (r < 2)
            it.mode = MODE_LOAD;
        else if (r == 2)
            it.mode = MODE_BEZIER + MODE_W'($urandom_range(1, 3));
        else
            it.mode = MODE_LINEAR + MODE_W'(r % 4);
        it.blend   = rand_blend();
        it.target  = rand_color();
        it.control = rand_color();
        return it;
    endfunction

    // offer one item and wait for it to be taken; valid stays up for a following item
    task automatic send_item(input step_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        tx_idle_pct = 8;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: move from reset, loads at the extremes
        send_item(mk(MODE_LINEAR, ONE >> 1, gray(MAXV), gray('0)));
        send_item(mk(MODE_LOAD, '0, gray('0), gray(MAXV)));
        send_item(mk(MODE_LOAD, MAXV, gray(ONE), gray('0)));
        send_item(mk(MODE_LINEAR, 17'd1, gray('0), gray(MAXV)));
        send_item(mk(MODE_LINEAR, ONE - 17'd1, gray('0), gray(MAXV)));
        send_item(mk(MODE_LOAD, '0, {MAXV, ONE, 17'd0}, gray('0)));
        // cosine at the ends, the middle and a table point
        send_item(mk(MODE_COSINE, 17'd1, gray(ONE), gray('0)));
        send_item(mk(MODE_COSINE, ONE - 17'd1, gray('0), gray('0)));
        send_item(mk(MODE_COSINE, ONE >> 1, {17'd0, MAXV, 17'd12345}, gray('0)));
        send_item(mk(MODE_COSINE, ONE >> 8, gray(MAXV), gray('0)));
        // smoothstep
        send_item(mk(MODE_SMOOTH, 17'd1, gray('0), gray('0)));
        send_item(mk(MODE_SMOOTH, ONE - 17'd1, {ONE, 17'd0, 17'd777}, gray('0)));
        send_item(mk(MODE_SMOOTH, ONE >> 1, gray(MAXV), gray('0)));
        // Bezier with extreme control colors
        send_item(mk(MODE_BEZIER, 17'd1, gray('0), gray(MAXV)));
        send_item(mk(MODE_BEZIER, ONE - 17'd1, gray(ONE), gray('0)));
        send_item(mk(MODE_BEZIER, ONE >> 1, gray('0), gray(MAXV)));
        // zero blend holds in every move mode
        send_item(mk(MODE_LINEAR, '0, gray(MAXV), gray(MAXV)));
        send_item(mk(MODE_COSINE, '0, gray('0), gray(MAXV)));
        send_item(mk(MODE_SMOOTH, '0, gray(ONE), gray('0)));
        send_item(mk(MODE_BEZIER, '0, gray('0), gray(MAXV)));
        // snap at one and above
        send_item(mk(MODE_COSINE, ONE, {17'd100, 17'd200, 17'd300}, gray('0)));
        send_item(mk(MODE_BEZIER, MAXV, gray(MAXV), gray('0)));
        // unused modes hold
        send_item(mk(MODE_BEZIER + 3'd1, ONE >> 1, gray('0), gray('0)));
        send_item(mk(MODE_BEZIER + 3'd2, MAXV, gray('0), gray(MAXV)));
        send_item(mk(MODE_BEZIER + 3'd3, 17'd1, gray(ONE), gray('0)));

        // random: sender idles little, receiver a lot
        repeat (PHASE_ITEMS) send_item(rand_item());

        // random: the other way round
        tx_idle_pct = 51;
        rx_idle_pct <= 8;
        repeat (PHASE_ITEMS) send_item(rand_item());

        // random: no idling, with one long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_go     <= 1'b1;
        repeat (PHASE_ITEMS) send_item(rand_item());

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
